@@ hw/rtl/ipv6_address_table_engine_macros.svh @@
// Assertion macros for the checker file of the address table engine.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef IPV6_ADDRESS_TABLE_ENGINE_MACROS_SVH
`define IPV6_ADDRESS_TABLE_ENGINE_MACROS_SVH
// Same-cycle implication, sampled on clk, disabled while in reset.
`define ATET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, disabled while in reset.
`define ATET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hw/rtl/atet_pkg.sv @@
// Types, codes and helper functions for the IPv6 address table engine.
// No dependencies; used by every module of the block except atet_ram.
`timescale 1ns / 1ps
package atet_pkg;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_DEL       = 3'd1;
  localparam logic [2:0] OP_EXACT     = 3'd2;
  localparam logic [2:0] OP_MASKED    = 3'd3;
  localparam logic [2:0] OP_SRCSEL    = 3'd4;
  localparam logic [2:0] OP_LINKLOCAL = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_PFX   = 2'd1;
  localparam logic [1:0] ST_EXISTS    = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [1:0] MAC_NONE   = 2'd0;
  localparam logic [1:0] MAC_ADD    = 2'd1;
  localparam logic [1:0] MAC_REMOVE = 2'd2;

  localparam logic [7:0]  PFX_MAX      = 8'd128;
  localparam logic [23:0] MCAST_OUI    = 24'h3333ff;
  localparam logic [7:0]  MCAST_BYTE   = 8'hff;
  localparam logic [3:0]  SCOPE_LINK   = 4'h2;
  localparam logic [3:0]  SCOPE_SITE   = 4'h5;
  localparam logic [3:0]  SCOPE_GLOBAL = 4'he;
  localparam logic [15:0] LL_PREFIX    = 16'hfe80;
  localparam logic [15:0] SL_PREFIX    = 16'hfec0;
  localparam logic [15:0] TEN_BIT_MASK = 16'hffc0;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  pfx;
  } entry_t;

  // Per-entry comparison results against the request key.
  typedef struct packed {
    logic       empty;
    logic       ex;
    logic       msk;
    logic       ll;
    logic       macm;
    logic [3:0] scope;
    logic [7:0] cpl;
  } cmp_t;

  function automatic logic is_ll(input logic [63:0] hi);
    return (hi[63:48] & TEN_BIT_MASK) == LL_PREFIX;
  endfunction

  function automatic logic [3:0] scope_of(input logic [63:0] hi);
    logic [3:0] s;
    if (hi[63:56] == MCAST_BYTE) s = hi[51:48];
    else if (is_ll(hi)) s = SCOPE_LINK;
    else if ((hi[63:48] & TEN_BIT_MASK) == SL_PREFIX) s = SCOPE_SITE;
    else s = SCOPE_GLOBAL;
    return s;
  endfunction

  function automatic logic [127:0] pfx_mask(input logic [7:0] p);
    logic [127:0] m;
    if (p == 8'd0) m = '0;
    else if (p >= PFX_MAX) m = '1;
    else m = ~128'd0 << (PFX_MAX - p);
    return m;
  endfunction

  // Leading zero count of a 128-bit word, 128 when the word is zero.
  function automatic logic [7:0] lead_zeros(input logic [127:0] x);
    logic [7:0] n;
    logic       seen;
    n    = PFX_MAX;
    seen = 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (!seen && x[127-i]) begin
        n    = 8'(i);
        seen = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

@@ hw/rtl/atet_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module atet_ram #(
  parameter int W = 8,
  parameter int D = 4
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic                           re,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/atet_cmp.sv @@
// Compare stage: matches one table entry against the request key, registered.
// Depends on atet_pkg.
`timescale 1ns / 1ps
module atet_cmp
  import atet_pkg::*;
#(
  parameter int IW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [IW-1:0] in_idx,
  input  logic          in_row_vld,
  input  entry_t        in_data,
  input  logic [63:0]   key_hi,
  input  logic [63:0]   key_lo,
  output logic          out_vld_r,
  output logic [IW-1:0] out_idx_r,
  output entry_t        out_ent_r,
  output cmp_t          out_cmp_r
);

  entry_t       ent;
  cmp_t         cm;
  logic [127:0] mk;
  logic [127:0] diff;

  always_comb begin
    // A row never written since reset reads as all zero.
    ent      = in_row_vld ? in_data : '0;
    mk       = pfx_mask(ent.pfx);
    diff     = {ent.hi ^ key_hi, ent.lo ^ key_lo};
    cm.empty = (ent.hi == 64'd0) && (ent.lo == 64'd0);
    cm.ex    = !cm.empty && (diff == 128'd0);
    cm.msk   = !cm.empty && ((diff & mk) == 128'd0);
    cm.ll    = is_ll(ent.hi);
    cm.macm  = ent.lo[23:0] == key_lo[23:0];
    cm.scope = scope_of(ent.hi);
    cm.cpl   = lead_zeros(diff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
    out_idx_r <= in_idx;
    out_ent_r <= ent;
    out_cmp_r <= cm;
  end

endmodule

@@ hw/rtl/ipv6_address_table_engine.sv @@
// IPv6 address table engine. The table of ENTRIES address/prefix rows lives in
// one synchronous RAM; every request beat reads the rows one per cycle through
// a compare stage, gathers the verdict, then writes at most one row back and
// loads the result register. The rows are read one at a time, since the table
// RAM has one read port. The result register is loaded only once the previous
// result beat has gone, so a stalled out_ready holds the request in S_FIN. A new
// request is taken once the previous one has been written back, even while its
// result beat still waits for out_ready. Reset empties the table at once through
// per-row valid flags, so no clearing pass is needed. Add and delete report the
// 33:33:ff multicast MAC to gain or lose.
`timescale 1ns / 1ps
module ipv6_address_table_engine
  import atet_pkg::*;
#(
  parameter int ENTRIES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [63:0] in_addr_hi,
  input  logic [63:0] in_addr_lo,
  input  logic [7:0]  in_prefix_len,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [3:0]  out_slot,
  output logic [63:0] out_out_addr_hi,
  output logic [63:0] out_out_addr_lo,
  output logic [7:0]  out_out_prefix,
  output logic [1:0]  out_mac_action,
  output logic [47:0] out_mcast_mac
);

  localparam int IW = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t        state_r;
  logic [2:0]    op_r;
  logic [63:0]   hi_r, lo_r;
  logic [7:0]    pl_r;
  logic [3:0]    sd_r;

  logic          rd_on_r;
  logic [IW-1:0] rd_idx_r;
  logic          p1_vld_r;
  logic [IW-1:0] p1_idx_r;
  logic          p1_rowv_r;
  logic [ENTRIES-1:0] vld_r;
  entry_t        rdata;

  logic          c_vld;
  logic [IW-1:0] c_idx;
  entry_t        c_ent;
  cmp_t          c_cm;

  // Gathered verdict of the scan.
  logic          rep_f_r;
  logic [IW-1:0] rep_idx_r;
  entry_t        rep_ent_r;
  logic          free_f_r, sc_f_r, keep_r, done_r;
  logic [IW-1:0] free_idx_r, sc_idx_r;
  logic [3:0]    sb_r;
  logic [7:0]    pb_r;

  logic          out_valid_r;
  logic [1:0]    status_r, mac_r;
  logic          found_r;
  logic [3:0]    slot_r;
  entry_t        oent_r;
  logic [47:0]   mmac_r;

  logic          accept, load, hitc, upd;
  logic          we;
  logic [IW-1:0] widx;
  entry_t        wdat;
  logic [1:0]    o_status, o_mac;
  logic          o_found;
  logic [IW-1:0] o_idx;
  entry_t        o_ent;
  logic [IW-1:0] tgt;
  logic          bad_pfx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load     = (state_r == S_FIN) && (!out_valid_r || out_ready);

  atet_ram #(.W($bits(entry_t)), .D(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (widx),
    .wdata (wdat),
    .re    (rd_on_r),
    .raddr (rd_idx_r),
    .rdata (rdata)
  );

  atet_cmp #(.IW(IW)) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (p1_vld_r),
    .in_idx     (p1_idx_r),
    .in_row_vld (p1_rowv_r),
    .in_data    (rdata),
    .key_hi     (hi_r),
    .key_lo     (lo_r),
    .out_vld_r  (c_vld),
    .out_idx_r  (c_idx),
    .out_ent_r  (c_ent),
    .out_cmp_r  (c_cm)
  );

  // First-hit condition for the lookups; source selection has its own rule.
  always_comb begin
    case (op_r)
      OP_ADD, OP_DEL, OP_EXACT: hitc = c_cm.ex;
      OP_MASKED:                hitc = c_cm.msk;
      OP_LINKLOCAL:             hitc = c_cm.ll;
      default:                  hitc = 1'b0;
    endcase
    // Rules 1, 2 and 8: the same address wins outright, then the scope
    // preference, then the longest common prefix within equal scope.
    upd = !done_r && !c_cm.empty &&
          (c_cm.ex ||
           ((c_cm.scope != sb_r) ?
             ((c_cm.scope < sb_r && c_cm.scope >= sd_r) ||
              (sb_r < c_cm.scope && sb_r < sd_r)) :
             (c_cm.cpl > pb_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_on_r  <= 1'b0;
      p1_vld_r <= 1'b0;
      vld_r    <= '0;
    end else begin
      p1_vld_r <= rd_on_r;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_SCAN;
            rd_on_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (rd_on_r && rd_idx_r == LAST) begin
            rd_on_r <= 1'b0;
          end
          if (c_vld && c_idx == LAST) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (we) begin
        vld_r[widx] <= 1'b1;
      end
    end
  end

  // Request capture, read addressing and verdict gathering.
  always_ff @(posedge clk) begin
    p1_idx_r  <= rd_idx_r;
    p1_rowv_r <= vld_r[rd_idx_r];
    if (accept) begin
      op_r       <= in_opcode;
      hi_r       <= in_addr_hi;
      lo_r       <= in_addr_lo;
      pl_r       <= in_prefix_len;
      sd_r       <= scope_of(in_addr_hi);
      rd_idx_r   <= '0;
      rep_f_r    <= 1'b0;
      free_f_r   <= 1'b0;
      sc_f_r     <= 1'b0;
      keep_r     <= 1'b0;
      done_r     <= 1'b0;
      sb_r       <= '0;
      pb_r       <= '0;
      rep_idx_r  <= '0;
      free_idx_r <= '0;
      sc_idx_r   <= '0;
    end else begin
      if (rd_on_r && rd_idx_r != LAST) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
      if (c_vld) begin
        if (op_r == OP_SRCSEL) begin
          if (c_idx == '0 || upd) begin
            rep_idx_r <= c_idx;
            rep_ent_r <= c_ent;
          end
          if (upd && c_cm.ex) begin
            done_r <= 1'b1;
          end else if (upd) begin
            sb_r <= c_cm.scope;
            pb_r <= c_cm.cpl;
          end
        end else if (!rep_f_r && hitc) begin
          rep_f_r   <= 1'b1;
          rep_idx_r <= c_idx;
          rep_ent_r <= c_ent;
        end
        if (!free_f_r) begin
          if (c_cm.empty) begin
            free_f_r   <= 1'b1;
            free_idx_r <= c_idx;
          end else if (c_cm.scope == sd_r) begin
            sc_f_r   <= 1'b1;
            sc_idx_r <= c_idx;
          end
        end
        if (!c_cm.empty && !c_cm.ex && c_cm.macm) begin
          keep_r <= 1'b1;
        end
      end
    end
  end

  // Final verdict and write-back.
  always_comb begin
    o_status = ST_OK;
    o_found  = 1'b0;
    o_idx    = '0;
    o_ent    = '0;
    o_mac    = MAC_NONE;
    we       = 1'b0;
    widx     = rep_idx_r;
    wdat     = '0;
    bad_pfx  = pl_r > PFX_MAX;
    tgt      = free_f_r ? free_idx_r : (sc_f_r ? sc_idx_r : '0);
    case (op_r)
      OP_ADD: begin
        if (bad_pfx) begin
          o_status = ST_BAD_PFX;
        end else if (rep_f_r) begin
          o_found   = 1'b1;
          o_idx     = rep_idx_r;
          o_ent     = rep_ent_r;
          o_ent.pfx = pl_r;
          if (rep_ent_r.pfx == pl_r) begin
            o_status = ST_EXISTS;
          end else begin
            we   = load;
            wdat = o_ent;
          end
        end else begin
          o_idx = tgt;
          o_ent = '{hi: hi_r, lo: lo_r, pfx: pl_r};
          we    = load;
          widx  = tgt;
          wdat  = o_ent;
          if (hi_r != 64'd0 || lo_r != 64'd0) begin
            o_mac = MAC_ADD;
          end
        end
      end
      OP_DEL: begin
        if (bad_pfx) begin
          o_status = ST_BAD_PFX;
        end else if (!rep_f_r || rep_ent_r.pfx != pl_r) begin
          o_status = ST_NOT_FOUND;
        end else begin
          o_found = 1'b1;
          o_idx   = rep_idx_r;
          o_ent   = rep_ent_r;
          we      = load;
          if (!keep_r) begin
            o_mac = MAC_REMOVE;
          end
        end
      end
      OP_EXACT, OP_MASKED, OP_LINKLOCAL: begin
        if (rep_f_r) begin
          o_found = 1'b1;
          o_idx   = rep_idx_r;
          o_ent   = rep_ent_r;
        end else begin
          o_status = ST_NOT_FOUND;
        end
      end
      OP_SRCSEL: begin
        o_idx = rep_idx_r;
        o_ent = rep_ent_r;
        if (rep_ent_r.hi == 64'd0 && rep_ent_r.lo == 64'd0) begin
          o_status = ST_NOT_FOUND;
        end else begin
          o_found = 1'b1;
        end
      end
      default: o_status = ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (load) begin
      status_r <= o_status;
      found_r  <= o_found;
      slot_r   <= 4'(o_idx);
      oent_r   <= o_ent;
      mac_r    <= o_mac;
      mmac_r   <= (o_mac == MAC_NONE) ? 48'd0 : {MCAST_OUI, lo_r[23:0]};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_found       = found_r;
  assign out_slot        = slot_r;
  assign out_out_addr_hi = oent_r.hi;
  assign out_out_addr_lo = oent_r.lo;
  assign out_out_prefix  = oent_r.pfx;
  assign out_mac_action  = mac_r;
  assign out_mcast_mac   = mmac_r;

endmodule

@@ hw/rtl/atet_chk.sv @@
// Port-level checker for the IPv6 address table engine, bound to the top level.
// Depends on atet_pkg and ipv6_address_table_engine_macros.svh.
`timescale 1ns / 1ps
`include "ipv6_address_table_engine_macros.svh"
module atet_chk
  import atet_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_found,
  input logic [1:0]  out_mac_action,
  input logic [47:0] out_mcast_mac
);

  `ATET_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped")
  `ATET_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second beat taken mid-request")
  `ATET_ASSERT_IMP(a_bad_pfx_quiet, out_valid && out_status == ST_BAD_PFX, !out_found && out_mac_action == MAC_NONE, "invalid prefix reported an entry")
  `ATET_ASSERT_IMP(a_mac_zero, out_valid && out_mac_action == MAC_NONE, out_mcast_mac == 48'd0, "stray multicast MAC")
  `ATET_ASSERT_IMP(a_mac_form, out_valid && out_mac_action != MAC_NONE, out_mcast_mac[47:24] == MCAST_OUI && out_status == ST_OK, "malformed MAC action")

endmodule

bind ipv6_address_table_engine atet_chk u_atet_chk (.*);

@@ tb/tb_ipv6_address_table_engine.sv @@
// Self-checking testbench for the IPv6 address table engine.
// Depends on atet_pkg and ipv6_address_table_engine; reads no files.
`timescale 1ns / 1ps
module tb_ipv6_address_table_engine;
  import atet_pkg::*;

  localparam int          SLOTS    = 4;
  localparam logic [2:0]  OP_RSVD6 = 3'd6;
  localparam logic [2:0]  OP_RSVD7 = 3'd7;
  localparam int          N_RAND   = 1430;
  localparam int          N_QUIET  = 150;

  // One result beat, laid out field by field as the block presents it.
  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [3:0]  slot;
    logic [63:0] ahi;
    logic [63:0] alo;
    logic [7:0]  pfx;
    logic [1:0]  mac;
    logic [47:0] mcast;
  } res_t;

  // One row of the directed table. When typed is set, the expected result
  // is the one written in the row rather than the predicted one.
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [7:0]  pl;
    logic        typed;
    res_t        exp_res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = '0;
  logic [63:0] in_addr_hi = '0;
  logic [63:0] in_addr_lo = '0;
  logic [7:0]  in_prefix_len = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_found;
  logic [3:0]  out_slot;
  logic [63:0] out_out_addr_hi;
  logic [63:0] out_out_addr_lo;
  logic [7:0]  out_out_prefix;
  logic [1:0]  out_mac_action;
  logic [47:0] out_mcast_mac;

  ipv6_address_table_engine #(.ENTRIES(SLOTS)) u_top (.*);

  // The clock runs at 50 MHz.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the address table, updated as each request beat is taken.
  logic [63:0] tbl_hi [SLOTS];
  logic [63:0] tbl_lo [SLOTS];
  logic [7:0]  tbl_pfx[SLOTS];

  res_t pending_results[$];
  int   errors = 0;
  bit   quiet = 1'b0;
  int   rx_stall = 0;

  function automatic logic [3:0] addr_scope(input logic [63:0] hi);
    if (hi[63:56] == 8'hff) return hi[51:48];
    if (hi[63:54] == 10'b1111111010) return SCOPE_LINK;
    if (hi[63:54] == 10'b1111111011) return SCOPE_SITE;
    return SCOPE_GLOBAL;
  endfunction

  function automatic logic [47:0] solicited_mac(input logic [63:0] lo);
    return {MCAST_OUI, lo[23:0]};
  endfunction

  // Length of the common leading part of two addresses, 128 when equal.
  function automatic int shared_bits(input logic [127:0] a, input logic [127:0] b);
    logic [127:0] x;
    x = a ^ b;
    for (int i = 0; i < 128; i++) if (x[127-i]) return i;
    return 128;
  endfunction

  function automatic bit slot_empty(input int i);
    return tbl_hi[i] == '0 && tbl_lo[i] == '0;
  endfunction

  function automatic int find_entry(input logic [63:0] hi, input logic [63:0] lo);
    for (int i = 0; i < SLOTS; i++)
      if (!slot_empty(i) && tbl_hi[i] == hi && tbl_lo[i] == lo) return i;
    return -1;
  endfunction

  function automatic res_t entry_report(input int i);
    res_t r;
    r = '0;
    r.found = 1'b1;
    r.slot  = 4'(i);
    r.ahi   = tbl_hi[i];
    r.alo   = tbl_lo[i];
    r.pfx   = tbl_pfx[i];
    return r;
  endfunction

  // Works out the result of one request and applies it to the shadow table.
  function automatic res_t table_request(input logic [2:0] op, input logic [63:0] hi,
                                         input logic [63:0] lo, input logic [7:0] pl);
    res_t         r;
    int           hit, best, sd, sb, pb, sc, pc;
    bit           keep;
    bit           same;
    logic [127:0] m;
    r = '0;
    r.status = ST_NOT_FOUND;
    case (op)
      OP_ADD, OP_DEL: begin
        if (pl > PFX_MAX) begin
          r.status = ST_BAD_PFX;
        end else if (op == OP_ADD) begin
          hit = find_entry(hi, lo);
          if (hit >= 0) begin
            // A known address either already exists or has its prefix updated.
            same = (tbl_pfx[hit] == pl);
            tbl_pfx[hit] = pl;
            r = entry_report(hit);
            if (same) r.status = ST_EXISTS;
          end else begin
            hit = 0;
            for (int i = 0; i < SLOTS; i++) begin
              if (slot_empty(i)) begin
                hit = i;
                break;
              end
              if (addr_scope(tbl_hi[i]) == addr_scope(hi)) hit = i;
            end
            tbl_hi[hit]  = hi;
            tbl_lo[hit]  = lo;
            tbl_pfx[hit] = pl;
            r = entry_report(hit);
            r.found = 1'b0;
            if (hi != '0 || lo != '0) begin
              r.mac   = MAC_ADD;
              r.mcast = solicited_mac(lo);
            end
          end
        end else begin
          hit = find_entry(hi, lo);
          if (hit >= 0 && tbl_pfx[hit] == pl) begin
            r = entry_report(hit);
            tbl_hi[hit]  = '0;
            tbl_lo[hit]  = '0;
            tbl_pfx[hit] = '0;
            keep = 1'b0;
            for (int i = 0; i < SLOTS; i++)
              if (!slot_empty(i) && !(tbl_hi[i] == hi && tbl_lo[i] == lo) &&
                  solicited_mac(tbl_lo[i]) == solicited_mac(lo)) keep = 1'b1;
            if (!keep) begin
              r.mac   = MAC_REMOVE;
              r.mcast = solicited_mac(lo);
            end
          end
        end
      end
      OP_EXACT, OP_MASKED: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_empty(i)) continue;
          if (tbl_pfx[i] == 0) m = '0;
          else if (tbl_pfx[i] >= PFX_MAX) m = '1;
          else m = ~128'd0 << (128 - tbl_pfx[i]);
          if (op == OP_EXACT ? ({tbl_hi[i], tbl_lo[i]} == {hi, lo}) :
              ((({tbl_hi[i], tbl_lo[i]} ^ {hi, lo}) & m) == '0)) begin
            r = entry_report(i);
            break;
          end
        end
      end
      OP_SRCSEL: begin
        // Rule 1 takes an equal address; rule 2 prefers the right scope;
        // rule 8 breaks ties by the longest matching prefix.
        sd = addr_scope(hi);
        sb = 0;
        pb = 0;
        best = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_empty(i)) continue;
          if (tbl_hi[i] == hi && tbl_lo[i] == lo) begin
            best = i;
            break;
          end
          sc = addr_scope(tbl_hi[i]);
          pc = shared_bits({tbl_hi[i], tbl_lo[i]}, {hi, lo});
          if (sc != sb) begin
            if ((sc < sb && sc >= sd) || (sb < sc && sb < sd)) begin
              best = i;
              sb = sc;
              pb = pc;
            end
          end else if (pc > pb) begin
            best = i;
            pb = pc;
          end
        end
        r = entry_report(best);
        if (slot_empty(best)) begin
          r.status = ST_NOT_FOUND;
          r.found  = 1'b0;
        end
      end
      OP_LINKLOCAL: begin
        for (int i = 0; i < SLOTS; i++)
          if (tbl_hi[i][63:54] == 10'b1111111010) begin
            r = entry_report(i);
            break;
          end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Presents one request beat and holds it until the block takes it.
  task automatic send_request(input logic [2:0] op, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [7:0] pl,
                              input bit typed, input res_t typed_res);
    res_t r;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_addr_hi    <= hi;
    in_addr_lo    <= lo;
    in_prefix_len <= pl;
    do @(posedge clk); while (!in_ready);
    r = table_request(op, hi, lo, pl);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // A burst of sender idling; valid drops only here and after the last beat.
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t mismatch on %s: expected %h, actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result side: compare every accepted beat, then choose the next ready.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t result beat with nothing expected: status %0d slot %0d",
                 $time, out_status, out_slot);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("found", e.found, out_found);
        check_field("slot", e.slot, out_slot);
        check_field("addr_hi", e.ahi, out_out_addr_hi);
        check_field("addr_lo", e.alo, out_out_addr_lo);
        check_field("prefix", e.pfx, out_out_prefix);
        check_field("mac_action", e.mac, out_mac_action);
        check_field("mcast_mac", e.mcast, out_mcast_mac);
      end
    end
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // A pool of addresses the random part draws on, so that adds, deletes
  // and lookups keep meeting each other in the four-slot table.
  logic [63:0] pool_hi [8];
  logic [63:0] pool_lo [8];
  logic [7:0]  pool_pfx[8];

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic refill_pool(input int j);
    logic [63:0] h;
    h = rnd64();
    case ($urandom_range(0, 5))
      0: h[63:54] = 10'b1111111010;
      1: h[63:54] = 10'b1111111011;
      2: h[63:56] = MCAST_BYTE;
      3: h = '0;
      default: ;
    endcase
    pool_hi[j] = h;
    pool_lo[j] = ($urandom_range(0, 4) == 0) ? 64'h0 : rnd64();
    // Some addresses share the low three bytes, so a MAC remove is held back.
    if ($urandom_range(0, 2) == 0) pool_lo[j][23:0] = pool_lo[(j + 1) % 8][23:0];
    case ($urandom_range(0, 3))
      0: pool_pfx[j] = 8'd0;
      1: pool_pfx[j] = 8'd64;
      2: pool_pfx[j] = PFX_MAX;
      default: pool_pfx[j] = 8'($urandom_range(0, 128));
    endcase
  endtask

  row_t directed[$];

  function automatic row_t plain(input logic [2:0] op, input logic [63:0] hi,
                                 input logic [63:0] lo, input logic [7:0] pl);
    return '{op, hi, lo, pl, 1'b0, '0};
  endfunction

  function automatic row_t typed_row(input logic [2:0] op, input logic [63:0] hi,
                                     input logic [63:0] lo, input logic [7:0] pl,
                                     input res_t r);
    return '{op, hi, lo, pl, 1'b1, r};
  endfunction

  initial begin
    res_t        nf, bad;
    logic [2:0]  op;
    logic [63:0] hi, lo;
    logic [7:0]  pl;
    int          j, s;
    nf  = '{ST_NOT_FOUND, 1'b0, 4'd0, 64'd0, 64'd0, 8'd0, MAC_NONE, 48'd0};
    bad = '{ST_BAD_PFX, 1'b0, 4'd0, 64'd0, 64'd0, 8'd0, MAC_NONE, 48'd0};
    for (int i = 0; i < SLOTS; i++) begin
      tbl_hi[i]  = '0;
      tbl_lo[i]  = '0;
      tbl_pfx[i] = '0;
    end

    // Empty table, prefix errors and unused opcodes, then a fill past capacity.
    directed.push_back(typed_row(OP_EXACT, '0, '0, 8'd0, nf));
    directed.push_back(typed_row(OP_LINKLOCAL, '1, '1, 8'd255, nf));
    directed.push_back(typed_row(OP_SRCSEL, 64'h2001_0db8_0000_0000, 64'h1, 8'd0, nf));
    directed.push_back(typed_row(OP_ADD, 64'hfe80_0000_0000_0000, 64'h1, 8'd129, bad));
    directed.push_back(typed_row(OP_ADD, '1, '1, 8'd255, bad));
    directed.push_back(typed_row(OP_DEL, 64'hfe80_0000_0000_0000, 64'h1, 8'd200, bad));
    directed.push_back(typed_row(OP_DEL, 64'hfe80_0000_0000_0000, 64'h1, 8'd64, nf));
    directed.push_back(typed_row(OP_RSVD6, '1, '1, 8'd64, nf));
    directed.push_back(typed_row(OP_RSVD7, '0, '0, 8'd0, nf));
    directed.push_back(typed_row(OP_ADD, 64'hfe80_0000_0000_0000, 64'h1, 8'd64,
                       '{ST_OK, 1'b0, 4'd0, 64'hfe80_0000_0000_0000, 64'h1, 8'd64,
                         MAC_ADD, 48'h3333ff000001}));
    directed.push_back(plain(OP_ADD, 64'h2001_0db8_0000_0000, 64'h1, 8'd128));
    directed.push_back(plain(OP_ADD, 64'h2001_0db8_0000_0000, 64'h1, 8'd128));
    directed.push_back(plain(OP_ADD, 64'h2001_0db8_0000_0000, 64'h1, 8'd48));
    directed.push_back(plain(OP_ADD, 64'hff02_0000_0000_0000, 64'h1_ff00_0001, 8'd0));
    directed.push_back(plain(OP_ADD, 64'hfec0_0000_0000_0000, 64'habcd, 8'd10));
    directed.push_back(plain(OP_ADD, '1, '1, 8'd128));
    directed.push_back(plain(OP_ADD, '0, '0, 8'd7));
    directed.push_back(plain(OP_EXACT, '1, '1, 8'd0));
    directed.push_back(plain(OP_MASKED, 64'hfe80_0000_0000_0000, 64'h5555, 8'd0));
    directed.push_back(plain(OP_SRCSEL, 64'hff02_0000_0000_0000, 64'h2, 8'd0));
    directed.push_back(plain(OP_LINKLOCAL, '0, '0, 8'd0));
    directed.push_back(plain(OP_DEL, 64'hfe80_0000_0000_0000, 64'h1, 8'd64));
    directed.push_back(plain(OP_DEL, 64'h2001_0db8_0000_0000, 64'h1, 8'd48));
    directed.push_back(plain(OP_ADD, '0, '0, 8'd100));
    directed.push_back(plain(OP_SRCSEL, '0, '0, 8'd0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      send_request(directed[k].op, directed[k].hi, directed[k].lo, directed[k].pl,
                   directed[k].typed, directed[k].exp_res);
      sender_gap();
    end

    for (int i = 0; i < 8; i++) refill_pool(i);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - N_QUIET) quiet = 1'b1;
      if ($urandom_range(0, 19) == 0) refill_pool($urandom_range(0, 7));
      j  = $urandom_range(0, 7);
      hi = pool_hi[j];
      lo = pool_lo[j];
      pl = pool_pfx[j];
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:  op = OP_ADD;
        6, 7, 8, 9:        op = OP_DEL;
        10, 11:            op = OP_EXACT;
        12, 13, 14:        op = OP_MASKED;
        15, 16, 17:        op = OP_SRCSEL;
        18:                op = OP_LINKLOCAL;
        default:           op = 3'($urandom_range(0, 7));
      endcase
      // Half of the deletes name an entry held in the shadow table, so they can succeed.
      if (op == OP_DEL && $urandom_range(0, 1) == 0) begin
        s  = $urandom_range(0, SLOTS - 1);
        hi = tbl_hi[s];
        lo = tbl_lo[s];
        pl = tbl_pfx[s];
      end
      if (op == OP_MASKED || op == OP_SRCSEL) lo = lo ^ (rnd64() >> $urandom_range(0, 63));
      case ($urandom_range(0, 15))
        0: begin
          hi = rnd64();
          lo = rnd64();
        end
        1: pl = 8'($urandom_range(0, 255));
        2: pl = 8'($urandom_range(129, 255));
        default: ;
      endcase
      send_request(op, hi, lo, pl, 1'b0, '0);
      sender_gap();
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/atet_pkg.sv
hw/rtl/atet_ram.sv
hw/rtl/atet_cmp.sv
hw/rtl/ipv6_address_table_engine.sv
hw/rtl/atet_chk.sv
tb/tb_ipv6_address_table_engine.sv
